// ===== rtl/multi_signature_payload_matcher_top_defines.svh =====
// assertion macros shared by the matcher rtl
// no dependencies
`ifndef MULTI_SIGNATURE_PAYLOAD_MATCHER_TOP_DEFINES_SVH
`define MULTI_SIGNATURE_PAYLOAD_MATCHER_TOP_DEFINES_SVH
`define MSPM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define MSPM_ASSERT_NEVER(lbl, cond, msg) \
  `MSPM_ASSERT(lbl, !(cond), msg)
`endif

// ===== rtl/mspm_pkg.sv =====
// types and codes for the signature matcher
// no dependencies
package mspm_pkg;
  localparam logic [1:0] OP_DATA  = 2'd0;
  localparam logic [1:0] OP_PAT   = 2'd1;
  localparam logic [1:0] OP_ATTR  = 2'd2;
  localparam logic [1:0] OP_CLEAR = 2'd3;
  localparam logic [1:0] SRC_PAY  = 2'd0;
  localparam logic [1:0] SRC_URI  = 2'd1;
  localparam logic [1:0] SRC_HOST = 2'd2;
  localparam logic [1:0] TGT_URI  = 2'd0;
  localparam logic [1:0] TGT_HOST = 2'd1;
  localparam logic [1:0] TGT_UA   = 2'd2;
  localparam logic [1:0] TGT_ANY  = 2'd3;
  localparam logic [1:0] REG_ACTIVE  = 2'd0;
  localparam logic [1:0] REG_LONGEST = 2'd1;
  localparam logic [1:0] REG_INSPECT = 2'd2;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
    logic [1:0] source;
    logic       field_end;
    logic       packet_end;
    logic [3:0] slot;
    logic [4:0] position;
    logic [5:0] pattern_length;
    logic       no_case;
    logic [1:0] target_kind;
    logic [1:0] severity_level;
    logic [3:0] category_code;
  } in_beat_t;

  typedef struct packed {
    logic       matched;
    logic [3:0] matched_slot;
    logic [1:0] found_in;
    logic [1:0] alert_severity;
    logic [3:0] alert_category;
  } out_beat_t;

  // per-slot view handed along the cell row
  typedef struct packed {
    logic       hit;
    logic [3:0] slot;
    logic [1:0] found_in;
    logic [1:0] severity;
    logic [3:0] category;
  } chain_t;

  function automatic logic [7:0] fold(input logic [7:0] c, input logic ci);
    if (ci && c >= 8'h41 && c <= 8'h5a) return c + 8'd32;
    return c;
  endfunction
endpackage

// ===== rtl/mspm_cell.sv =====
// one signature slot: pattern, attributes, hit bits, result chain stage
// depends on mspm_pkg
module mspm_cell #(
  parameter int MAX_LEN = 32,
  parameter int IDX     = 0
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   step_i,
  input  mspm_pkg::in_beat_t     beat_i,
  input  logic [5:0]             longest_i,
  input  logic                   enabled_i,
  input  logic                   scan_i,
  input  logic [8*MAX_LEN-1:0]   win_i,
  input  logic [6:0]             fill_i,
  input  logic                   chain_go_i,
  input  logic                   hits_clr_i,
  input  mspm_pkg::chain_t       chain_i,
  output mspm_pkg::chain_t       chain_o
);
  import mspm_pkg::*;
  localparam int PW = $clog2(MAX_LEN);
  localparam int LW = $clog2(MAX_LEN + 1);

  logic [7:0]    pat_q [MAX_LEN];
  logic [LW-1:0] len_q;
  logic          ci_q;
  logic [1:0]    tgt_q, sev_q;
  logic [3:0]    cat_q;
  logic [2:0]    hits_q, hits_d;
  logic          mine, match;
  logic [1:0]    where;
  logic          found;
  chain_t        chain_d;

  assign mine = ({28'd0, beat_i.slot} == 32'(IDX));

  always_comb begin
    match = (len_q != '0) && ({1'b0, fill_i} + 8'd1 >= 8'(len_q));
    for (int k = 0; k < MAX_LEN; k++) begin
      if (k < int'(len_q)) begin
        if (fold(win_i[8*k +: 8], ci_q) != fold(pat_q[PW'(int'(len_q) - 1 - k)], ci_q)) begin
          match = 1'b0;
        end
      end
    end
  end

  always_comb begin
    found = 1'b0;
    where = SRC_PAY;
    unique case (tgt_q)
      TGT_URI: begin
        if (hits_q[1]) begin found = 1'b1; where = SRC_URI; end
        else if (hits_q[0]) begin found = 1'b1; where = SRC_PAY; end
      end
      TGT_HOST: begin
        if (hits_q[2]) begin found = 1'b1; where = SRC_HOST; end
      end
      TGT_UA: begin
        if (hits_q[0]) begin found = 1'b1; where = SRC_PAY; end
      end
      default: begin
        if (hits_q[0]) begin found = 1'b1; where = SRC_PAY; end
        else if (hits_q[1]) begin found = 1'b1; where = SRC_URI; end
        else if (hits_q[2]) begin found = 1'b1; where = SRC_HOST; end
      end
    endcase
    chain_d = chain_i;
    if (!chain_i.hit && enabled_i && len_q != '0 && found) begin
      chain_d.hit      = 1'b1;
      chain_d.slot     = 4'(IDX);
      chain_d.found_in = where;
      chain_d.severity = sev_q;
      chain_d.category = cat_q;
    end
  end

  // result walks one cell per cycle toward the top slot
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chain_o <= '0;
    end else if (chain_go_i) begin
      chain_o <= chain_d;
    end
  end

  always_comb begin
    hits_d = hits_q;
    if (scan_i && enabled_i && match) hits_d[beat_i.source] = 1'b1;
  end

  always_ff @(posedge clk_i) begin
    if (step_i && beat_i.opcode == OP_PAT && mine && int'(beat_i.position) < MAX_LEN) begin
      pat_q[beat_i.position[PW-1:0]] <= beat_i.data_byte;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q  <= '0;
      ci_q   <= 1'b0;
      tgt_q  <= '0;
      sev_q  <= '0;
      cat_q  <= '0;
      hits_q <= '0;
    end else if (step_i) begin
      unique case (beat_i.opcode)
        OP_ATTR: begin
          if (mine) begin
            if (beat_i.pattern_length == '0 || beat_i.pattern_length > longest_i ||
                int'(beat_i.pattern_length) > MAX_LEN) len_q <= '0;
            else len_q <= LW'(beat_i.pattern_length);
            ci_q  <= beat_i.no_case;
            tgt_q <= beat_i.target_kind;
            sev_q <= beat_i.severity_level;
            cat_q <= beat_i.category_code;
          end
        end
        OP_CLEAR: begin
          len_q <= '0; ci_q <= 1'b0; tgt_q <= '0; sev_q <= '0; cat_q <= '0;
          hits_q <= '0;
        end
        OP_DATA: hits_q <= hits_d;
        default: ;
      endcase
    end else if (hits_clr_i) begin
      hits_q <= '0;
    end
  end
endmodule

// ===== rtl/multi_signature_payload_matcher_top.sv =====
// Signature matcher: one data, load or clear beat is taken per cycle while no result walk
// runs. Slots sit in a row of cells that all compare the current byte against the shared
// byte window in that cycle. On packet end the result walks the cell row one slot per cycle
// and reaches the output register once it has passed the top cell; only then is the next beat
// taken, and a result still stalled in the output register holds the walk at its last step until
// it leaves.
// depends on mspm_pkg, mspm_cell and the defines header
`include "multi_signature_payload_matcher_top_defines.svh"
module multi_signature_payload_matcher_top #(
  parameter int SLOTS   = 16,
  parameter int MAX_LEN = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  mspm_pkg::in_beat_t   in_data_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output mspm_pkg::out_beat_t  out_data_o,
  input  logic                 psel,
  input  logic                 penable,
  input  logic                 pwrite,
  input  logic [3:0]           paddr,
  input  logic [31:0]          pwdata,
  output logic [31:0]          prdata,
  output logic                 pready
);
  import mspm_pkg::*;
  localparam int CW = $clog2(SLOTS + 2);

  logic [4:0]  active_q;
  logic [5:0]  longest_q;
  logic [15:0] inspect_q;
  logic [15:0] seen_q;
  logic [8*(MAX_LEN-1)-1:0] win_q;
  logic [6:0]  fill_q;
  logic        busy_q;
  logic [CW-1:0] cnt_q;
  logic        step, scan, data_ok, walk_done;
  logic [8*MAX_LEN-1:0] win_cur;
  chain_t      chain [SLOTS+1];
  logic [1:0]  reg_idx;

  assign pready     = 1'b1;
  assign in_stall_o = busy_q;
  assign step       = in_valid_i && !in_stall_o;
  assign reg_idx    = paddr[3:2];
  assign data_ok    = in_data_i.opcode == OP_DATA && in_data_i.source != 2'd3;
  assign scan = step && data_ok &&
                (in_data_i.source != SRC_PAY || seen_q < inspect_q);
  assign win_cur = {win_q, in_data_i.data_byte};
  assign chain[0] = '0;
  assign walk_done = busy_q && cnt_q == CW'(SLOTS) && !(out_valid_o && out_stall_i);

  always_comb begin
    unique case (reg_idx)
      REG_ACTIVE:  prdata = {27'd0, active_q};
      REG_LONGEST: prdata = {26'd0, longest_q};
      REG_INSPECT: prdata = {16'd0, inspect_q};
      default:     prdata = '0;
    endcase
  end

  for (genvar s = 0; s < SLOTS; s++) begin : g_cell
    mspm_cell #(.MAX_LEN(MAX_LEN), .IDX(s)) u_cell (
      .clk_i, .rst_ni,
      .step_i     (step),
      .beat_i     (in_data_i),
      .longest_i  (longest_q),
      .enabled_i  (32'(s) < 32'(active_q)),
      .scan_i     (scan),
      .win_i      (win_cur),
      .fill_i     (fill_q),
      .chain_go_i (busy_q),
      .hits_clr_i (walk_done),
      .chain_i    (chain[s]),
      .chain_o    (chain[s+1])
    );
  end

  always_ff @(posedge clk_i) begin
    if (scan) win_q <= win_cur[8*(MAX_LEN-1)-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 5'd16;
      longest_q   <= 6'd32;
      inspect_q   <= 16'd4096;
      seen_q      <= '0;
      fill_q      <= '0;
      busy_q      <= 1'b0;
      cnt_q       <= '0;
      out_valid_o <= 1'b0;
      out_data_o  <= '0;
    end else begin
      if (psel && penable && pwrite) begin
        unique case (reg_idx)
          REG_ACTIVE:  active_q  <= pwdata[4:0];
          REG_LONGEST: longest_q <= pwdata[5:0];
          REG_INSPECT: inspect_q <= pwdata[15:0];
          default: ;
        endcase
      end
      if (walk_done) begin
        out_valid_o <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        out_valid_o <= 1'b0;
      end
      if (step && in_data_i.opcode == OP_DATA) begin
        if (in_data_i.packet_end) begin
          fill_q <= '0;
          seen_q <= '0;
          busy_q <= 1'b1;
          cnt_q  <= '0;
        end else begin
          if (data_ok && in_data_i.source == SRC_PAY && seen_q != 16'hffff)
            seen_q <= seen_q + 16'd1;
          if (in_data_i.field_end) fill_q <= '0;
          else if (scan && fill_q < 7'(MAX_LEN - 1)) fill_q <= fill_q + 7'd1;
        end
      end
      if (walk_done) begin
        busy_q                    <= 1'b0;
        out_data_o.matched        <= chain[SLOTS].hit;
        out_data_o.matched_slot   <= chain[SLOTS].slot;
        out_data_o.found_in       <= chain[SLOTS].found_in;
        out_data_o.alert_severity <= chain[SLOTS].severity;
        out_data_o.alert_category <= chain[SLOTS].category;
      end else if (busy_q && cnt_q != CW'(SLOTS)) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  `MSPM_ASSERT_NEVER(a_no_take_busy, step && busy_q, "beat taken during result walk")
  `MSPM_ASSERT(a_fill_cap, fill_q <= 7'(MAX_LEN - 1), "window fill overflow")
  `MSPM_ASSERT(a_walk_done, (busy_q && cnt_q == CW'(SLOTS)) |=> out_valid_o, "result not posted")
endmodule

// ===== tb/sv/multi_signature_payload_matcher_top_test.sv =====
// testbench for the signature matcher: directed and random packets, slot loads and register
// settings, checked against an in-bench predictor through a small scoreboard class
// depends on mspm_pkg and the matcher rtl
module multi_signature_payload_matcher_top_test;
  timeunit 1ns;
  timeprecision 1ps;
  import mspm_pkg::*;

  localparam int NSLOT = 16;
  localparam int PLEN = 32;
  localparam longint CYCLE_LIMIT = 2000000;

  class match_scoreboard;
    logic [7:0] pat_bytes [NSLOT*PLEN];
    logic [5:0] len_q [NSLOT];
    logic ci_q [NSLOT];
    logic [1:0] tgt_q [NSLOT];
    logic [1:0] sev_q [NSLOT];
    logic [3:0] cat_q [NSLOT];
    logic [2:0] hits_q [NSLOT];
    logic [7:0] window [PLEN-1];
    int fill;
    int pay_count;
    int active_cnt;
    int longest_len;
    int inspect_lim;
    out_beat_t pending_results [$];
    int mismatches;

    function void clear_slots();
      for (int s = 0; s < NSLOT; s++) begin
        len_q[s] = '0; ci_q[s] = 1'b0; tgt_q[s] = '0; sev_q[s] = '0; cat_q[s] = '0;
        hits_q[s] = '0;
      end
    endfunction

    function void init();
      clear_slots();
      for (int i = 0; i < PLEN-1; i++) window[i] = '0;
      for (int i = 0; i < NSLOT*PLEN; i++) pat_bytes[i] = '0;
      fill = 0; pay_count = 0; mismatches = 0;
      active_cnt = 16; longest_len = 32; inspect_lim = 4096;
    endfunction

    function logic [7:0] lc(logic [7:0] c, logic ci);
      return (ci && c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function bit hit_now(int s, logic [7:0] cur);
      int l;
      logic [7:0] b;
      l = len_q[s];
      if (l == 0 || fill + 1 < l) return 0;
      for (int k = 0; k < l; k++) begin
        b = (k == 0) ? cur : window[k-1];
        if (lc(b, ci_q[s]) != lc(pat_bytes[s*PLEN + l-1-k], ci_q[s])) return 0;
      end
      return 1;
    endfunction

    function bit choose_source(int s, output logic [1:0] where);
      logic [2:0] h;
      h = hits_q[s];
      where = SRC_PAY;
      case (tgt_q[s])
        TGT_URI: begin
          if (h[1]) begin where = SRC_URI; return 1; end
          return h[0];
        end
        TGT_HOST: begin
          where = SRC_HOST; return h[2];
        end
        TGT_UA: return h[0];
        default: begin
          if (h[0]) return 1;
          if (h[1]) begin where = SRC_URI; return 1; end
          if (h[2]) begin where = SRC_HOST; return 1; end
          return 0;
        end
      endcase
    endfunction

    function void note_beat(in_beat_t b);
      int n;
      bit scan;
      out_beat_t r;
      logic [1:0] where;
      n = active_cnt > NSLOT ? NSLOT : active_cnt;
      case (b.opcode)
        OP_PAT: pat_bytes[b.slot*PLEN + b.position] = b.data_byte;
        OP_ATTR: begin
          len_q[b.slot] = (b.pattern_length == 0 || b.pattern_length > longest_len ||
                           b.pattern_length > PLEN) ? 6'd0 : b.pattern_length;
          ci_q[b.slot] = b.no_case;
          tgt_q[b.slot] = b.target_kind;
          sev_q[b.slot] = b.severity_level;
          cat_q[b.slot] = b.category_code;
        end
        OP_CLEAR: clear_slots();
        default: begin
          if (b.source != 2'd3) begin
            scan = 1;
            if (b.source == SRC_PAY) begin
              scan = pay_count < inspect_lim;
              if (pay_count < 65535) pay_count++;
            end
            if (scan) begin
              for (int s = 0; s < n; s++)
                if (hit_now(s, b.data_byte)) hits_q[s][b.source] = 1'b1;
              for (int i = PLEN-2; i > 0; i--) window[i] = window[i-1];
              window[0] = b.data_byte;
              if (fill < PLEN-1) fill++;
            end
          end
          if (b.field_end) fill = 0;
          if (b.packet_end) begin
            r = '0;
            for (int s = 0; s < n; s++)
              if (len_q[s] != 0 && choose_source(s, where)) begin
                r.matched = 1'b1; r.matched_slot = 4'(s); r.found_in = where;
                r.alert_severity = sev_q[s]; r.alert_category = cat_q[s];
                break;
              end
            pending_results = {pending_results, r};
            for (int s = 0; s < NSLOT; s++) hits_q[s] = '0;
            fill = 0; pay_count = 0;
          end
        end
      endcase
    endfunction

    function void check_result(out_beat_t got);
      out_beat_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", got);
        return;
      end
      want = pending_results.pop_front();
      if (got !== want) begin
        mismatches++;
        if (mismatches <= 10) $display("result mismatch: expected %h actual %h", want, got);
      end
    endfunction
  endclass

  logic clk_i, rst_ni;
  logic in_valid_i, in_stall_o, out_valid_o, out_stall_i;
  in_beat_t in_data_i;
  out_beat_t out_data_o;
  logic psel, penable, pwrite, pready;
  logic [3:0] paddr;
  logic [31:0] pwdata, prdata;

  multi_signature_payload_matcher_top dut (.*);

  match_scoreboard sb;
  longint cycles;
  int rx_hold;
  int long_hold;
  bit rx_idle_mode;
  int pats_len [NSLOT];
  int sent;

  initial begin
    clk_i = 0;
    forever #6 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  // receiver side: random stalls per beat, plus a long hold-off when requested
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (long_hold > 0) begin
        long_hold <= long_hold - 1;
        out_stall_i <= 1'b1;
      end else if (rx_hold > 0) begin
        rx_hold <= rx_hold - 1;
        out_stall_i <= 1'b1;
      end else if (out_valid_o && !out_stall_i) begin
        rx_hold <= rx_idle_mode ? 0 : $urandom_range(0, 19);
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  bit tx_gaps;

  task automatic send_beat(in_beat_t b);
    int gap;
    gap = tx_gaps ? $urandom_range(0, 19) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= b;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_beat(b);
    sent++;
  endtask

  task automatic reg_write(logic [1:0] idx, logic [31:0] val);
    psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(posedge clk_i);
    penable <= 1;
    do @(posedge clk_i); while (!pready);
    psel <= 0; penable <= 0; pwrite <= 0;
    case (idx)
      REG_ACTIVE: sb.active_cnt = val[4:0];
      REG_LONGEST: sb.longest_len = val[5:0];
      default: sb.inspect_lim = val[15:0];
    endcase
    @(posedge clk_i);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (NSLOT + 8) @(posedge clk_i);
  endtask

  function automatic in_beat_t blank();
    in_beat_t b;
    b = '0;
    b.opcode = OP_DATA;
    return b;
  endfunction

  task automatic load_slot(int s, int l, logic [7:0] pat [PLEN], logic ci, logic [1:0] tg);
    in_beat_t b;
    for (int p = 0; p < l && p < PLEN; p++) begin
      b = blank(); b.opcode = OP_PAT; b.slot = 4'(s); b.position = 5'(p);
      b.data_byte = pat[p];
      b.source = 2'($urandom); b.packet_end = 1'($urandom);
      send_beat(b);
    end
    b = blank(); b.opcode = OP_ATTR; b.slot = 4'(s); b.pattern_length = 6'(l);
    b.no_case = ci; b.target_kind = tg; b.severity_level = 2'($urandom);
    b.category_code = 4'($urandom); b.position = 5'($urandom); b.data_byte = 8'($urandom);
    send_beat(b);
    pats_len[s] = (l > PLEN) ? 0 : (l > pats_len[s] ? l : pats_len[s]);
  endtask

  // fills every pattern byte so no unwritten byte is ever compared
  task automatic load_all_patterns();
    logic [7:0] pat [PLEN];
    for (int s = 0; s < NSLOT; s++) begin
      for (int p = 0; p < PLEN; p++) pat[p] = 8'("a" + $urandom_range(0, 3));
      load_slot(s, PLEN, pat, 1'($urandom), 2'($urandom));
    end
  endtask

  task automatic rand_attrs(int s);
    in_beat_t b;
    b = blank(); b.opcode = OP_ATTR; b.slot = 4'(s);
    b.pattern_length = ($urandom_range(0, 9) == 0) ? 6'($urandom_range(0, 63))
                                                    : 6'($urandom_range(1, 6));
    b.no_case = 1'($urandom); b.target_kind = 2'($urandom);
    b.severity_level = 2'($urandom); b.category_code = 4'($urandom);
    send_beat(b);
  endtask

  task automatic rand_packet(int nbytes);
    in_beat_t b;
    int s;
    for (int i = 0; i < nbytes; i++) begin
      b = blank();
      b.source = ($urandom_range(0, 15) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
      b.data_byte = ($urandom_range(0, 7) == 0) ? 8'($urandom)
                                                : 8'("a" + $urandom_range(0, 3));
      if ($urandom_range(0, 5) == 0) b.data_byte = 8'("A" + $urandom_range(0, 3));
      if ($urandom_range(0, 3) == 0 && pats_len[0] > 0) begin
        s = $urandom_range(0, NSLOT-1);
        b.data_byte = sb.pat_bytes[s*PLEN + $urandom_range(0, PLEN-1)];
      end
      b.field_end = ($urandom_range(0, 9) == 0);
      b.packet_end = (i == nbytes-1);
      b.slot = 4'($urandom); b.position = 5'($urandom); b.pattern_length = 6'($urandom);
      b.no_case = 1'($urandom); b.target_kind = 2'($urandom);
      b.severity_level = 2'($urandom); b.category_code = 4'($urandom);
      send_beat(b);
    end
  endtask

  task automatic planted_packet();
    in_beat_t b;
    int s, l;
    s = $urandom_range(0, NSLOT-1);
    l = sb.len_q[s];
    if (l == 0) l = 3;
    for (int i = 0; i < l; i++) begin
      b = blank();
      b.source = 2'($urandom_range(0, 2));
      b.data_byte = sb.pat_bytes[s*PLEN + i];
      if ($urandom_range(0, 1)) b.data_byte = b.data_byte ^ 8'h20;
      send_beat(b);
    end
    rand_packet($urandom_range(1, 4));
  endtask

  initial begin
    in_beat_t b;
    logic [7:0] pat [PLEN];
    sb = new();
    sb.init();
    cycles = 0; rx_hold = 0; long_hold = 0; rx_idle_mode = 0; tx_gaps = 0; sent = 0;
    rst_ni = 0; in_valid_i = 0; in_data_i = '0; out_stall_i = 0;
    psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
    for (int s = 0; s < NSLOT; s++) pats_len[s] = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed part
    b = blank(); b.packet_end = 1; send_beat(b);
    load_all_patterns();
    for (int p = 0; p < PLEN; p++) pat[p] = 8'hff;
    load_slot(15, PLEN, pat, 0, TGT_ANY);
    b = blank(); b.opcode = OP_ATTR; b.slot = 3; b.pattern_length = 33; send_beat(b);
    b = blank(); b.opcode = OP_PAT; b.slot = 1; b.position = 31; b.data_byte = 0;
    send_beat(b);
    b = blank(); b.opcode = OP_PAT; b.slot = 1; b.position = 0; b.data_byte = "Q";
    send_beat(b);
    b = blank(); b.opcode = OP_ATTR; b.slot = 1; b.pattern_length = 1;
    b.no_case = 1; b.target_kind = TGT_UA; b.severity_level = 3;
    b.category_code = 15; send_beat(b);
    b = blank(); b.data_byte = "q"; b.source = SRC_PAY; send_beat(b);
    b = blank(); b.data_byte = "q"; b.source = 2'd3; b.field_end = 1; b.packet_end = 1;
    send_beat(b);
    b = blank(); b.data_byte = 8'hff; b.source = SRC_HOST; b.packet_end = 1; send_beat(b);
    b = blank(); b.opcode = OP_CLEAR; send_beat(b);
    b = blank(); b.data_byte = "q"; b.packet_end = 1; send_beat(b);
    drain();

    // random phases across register settings
    tx_gaps = 1;
    for (int ph = 0; ph < 8; ph++) begin
      case (ph)
        0: begin reg_write(REG_ACTIVE, 0); reg_write(REG_LONGEST, 1);
                 reg_write(REG_INSPECT, 0); end
        1: begin reg_write(REG_ACTIVE, 16); reg_write(REG_LONGEST, 32);
                 reg_write(REG_INSPECT, 65535); end
        2: begin reg_write(REG_ACTIVE, 31); reg_write(REG_LONGEST, 63);
                 reg_write(REG_INSPECT, 3); end
        3: begin reg_write(REG_ACTIVE, 5); reg_write(REG_LONGEST, 4);
                 reg_write(REG_INSPECT, 10); end
        default: begin reg_write(REG_ACTIVE, $urandom_range(0, 31));
                 reg_write(REG_LONGEST, $urandom_range(0, 63));
                 reg_write(REG_INSPECT, $urandom); end
      endcase
      tx_gaps = (ph != 4 && ph != 5);
      rx_idle_mode = (ph == 6);
      if (ph == 4) long_hold <= 400;
      for (int k = 0; k < 8; k++) begin
        case ($urandom_range(0, 9))
          0: rand_attrs($urandom_range(0, NSLOT-1));
          1: begin
            b = blank(); b.opcode = OP_PAT; b.slot = 4'($urandom); b.position = 5'($urandom);
            b.data_byte = 8'("a" + $urandom_range(0, 3)); send_beat(b);
          end
          2: planted_packet();
          default: rand_packet($urandom_range(1, 12));
        endcase
        if ($urandom_range(0, 40) == 0) begin
          b = blank(); b.opcode = OP_CLEAR; send_beat(b);
          for (int s = 0; s < 4; s++) rand_attrs(s);
        end
      end
      drain();
    end
    while (sent < 1050) begin
      rand_packet($urandom_range(1, 12));
      if ($urandom_range(0, 8) == 0) rand_attrs($urandom_range(0, NSLOT-1));
    end
    drain();
    if (sb.mismatches == 0 && sb.pending_results.size() == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end
endmodule
